// File: src/rtli_pkg.sv
package rtli_pkg;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  localparam int unsigned ScoreW = 31;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned RrankW = 5;
  localparam int unsigned PrankW = 5;
  localparam int unsigned EcntW  = 6;

  // One list entry
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [TimeW-1:0]  time_ms;
    logic [ScoreW-1:0] score;
  } entry_t;

  // Control part of the token that walks down the cell chain
  typedef struct packed {
    logic              active;
    logic              ins;
    logic              done;
    logic [RrankW-1:0] read_rank;
  } link_t;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic [EcntW-1:0]  entry_count;
    logic [TagW-1:0]   entry_tag;
    logic [TimeW-1:0]  entry_time;
    logic [ScoreW-1:0] entry_score;
    logic              entry_valid;
    logic [PrankW-1:0] placed_rank;
    logic              placed;
  } result_t;

endpackage

// File: src/rtli_cell.sv
module rtli_cell import rtli_pkg::*; #(
  parameter int unsigned CNT_W  = 6,
  parameter int unsigned RANK_W = 5,
  parameter int unsigned POS    = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  count_i,
  input  link_t             link_i,
  input  entry_t            dat_i,
  input  logic [RANK_W-1:0] rank_i,
  output link_t             link_o,
  output entry_t            dat_o,
  output logic [RANK_W-1:0] rank_o
);

  localparam logic [CNT_W-1:0]  PosCnt  = CNT_W'(POS);
  localparam logic [RANK_W-1:0] PosRank = RANK_W'(POS);

  entry_t            own_q, own_d;
  link_t             link_q, link_d;
  entry_t            dat_q, dat_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              live;
  logic              ahead;
  logic              hit;

  // this cell holds an entry, and the carried entry outranks or ties it
  assign live  = (count_i > PosCnt);
  assign ahead = (own_q.score < dat_i.score) ||
                 ((own_q.score == dat_i.score) && (own_q.time_ms >= dat_i.time_ms));
  assign hit   = ({27'd0, link_i.read_rank} == 32'(POS));

  // insert swaps the carried entry in, read picks up the own entry
  always_comb begin
    own_d  = own_q;
    link_d = link_i;
    dat_d  = dat_i;
    rank_d = rank_i;
    if (link_i.active) begin
      if (link_i.ins) begin
        if (link_i.done) begin
          own_d = dat_i;
          dat_d = own_q;
        end else if (!live || ahead) begin
          own_d       = dat_i;
          dat_d       = own_q;
          link_d.done = 1'b1;
          rank_d      = PosRank;
        end
      end else if (!link_i.done && live && hit) begin
        dat_d       = own_q;
        link_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q  <= own_d;
    dat_q  <= dat_d;
    rank_q <= rank_d;
  end

  assign link_o = link_q;
  assign dat_o  = dat_q;
  assign rank_o = rank_q;

endmodule

// File: src/rtli_outq.sv
module rtli_outq import rtli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    spare_full_o
);

  logic    head_v_q, head_v_d;
  logic    spare_v_q, spare_v_d;
  result_t head_q, head_d;
  result_t spare_q, spare_d;
  logic    pop;

  assign pop = head_v_q && ready_i;

  // head register feeds the port, spare catches a beat while head stalls
  always_comb begin
    head_v_d  = head_v_q;
    head_d    = head_q;
    spare_v_d = spare_v_q;
    spare_d   = spare_q;
    if (!head_v_q || pop) begin
      if (spare_v_q) begin
        head_v_d  = 1'b1;
        head_d    = spare_q;
        spare_v_d = push_i;
        spare_d   = push_data_i;
      end else begin
        head_v_d = push_i;
        head_d   = push_data_i;
      end
    end else if (push_i) begin
      spare_v_d = 1'b1;
      spare_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      head_v_q  <= head_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign valid_o      = head_v_q;
  assign data_o       = head_q;
  assign spare_full_o = spare_v_q;

endmodule

// File: src/ranked_top_list_insert.sv
// Channel  Dir  Beat contents
// s_axis   in   tuser: command; tdata: new_score, new_time, new_tag, read_rank
// m_axis   out  tdata: placed, placed_rank, entry_valid, entry_score,
//               entry_time, entry_tag, entry_count
//
// Insert and read send a token through a row of LIST_ENTRIES cells, one cell
// per cycle; the result beat can be taken at the same edge as the next input
// beat. Clear and the unused command can be taken on the next cycle.
// Reset empties the list at once; entry storage is not cleared.
// A two-deep result buffer keeps the input open while one result waits.
module ranked_top_list_insert import rtli_pkg::*; #(
  parameter int unsigned LIST_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [30:0] new_score, [62:31] new_time, [78:63] new_tag, [83:79] read_rank
  input  logic [87:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] placed, [5:1] placed_rank, [6] entry_valid, [37:7] entry_score,
  // [69:38] entry_time, [85:70] entry_tag, [91:86] entry_count
  output logic [95:0] m_axis_tdata_o
);

  localparam int unsigned CntW  = $clog2(LIST_ENTRIES + 1);
  localparam int unsigned RankW = $clog2(LIST_ENTRIES);
  localparam logic [CntW-1:0] FullCnt = CntW'(LIST_ENTRIES);

  logic [CntW-1:0]  count_q, count_d;
  logic             busy_q, busy_d;
  link_t            launch_q, launch_d;
  entry_t           ldat_q, ldat_d;
  link_t            link_w [LIST_ENTRIES+1];
  entry_t           dat_w  [LIST_ENTRIES+1];
  logic [RankW-1:0] rank_w [LIST_ENTRIES+1];
  logic             accept;
  cmd_e             cmd;
  logic             walk_cmd;
  logic             fin_v;
  result_t          fin;
  result_t          out_data;
  logic             spare_full;
  link_t            ex;
  logic             ex_place;
  logic             ex_read;

  assign cmd      = cmd_e'(s_axis_tuser_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign walk_cmd = (cmd == CMD_INSERT) || (cmd == CMD_READ);
  assign s_axis_tready_o = !busy_q && !spare_full;

  // token launch into the first cell
  always_comb begin
    launch_d        = '0;
    ldat_d          = ldat_q;
    if (accept && walk_cmd) begin
      launch_d.active    = 1'b1;
      launch_d.ins       = (cmd == CMD_INSERT);
      launch_d.read_rank = s_axis_tdata_i[83:79];
      ldat_d.score       = s_axis_tdata_i[30:0];
      ldat_d.time_ms     = s_axis_tdata_i[62:31];
      ldat_d.tag         = s_axis_tdata_i[78:63];
    end
  end

  assign link_w[0] = launch_q;
  assign dat_w[0]  = ldat_q;
  assign rank_w[0] = '0;

  // the cell row
  for (genvar k = 0; k < LIST_ENTRIES; k++) begin : g_cell
    rtli_cell #(
      .CNT_W  (CntW),
      .RANK_W (RankW),
      .POS    (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .link_i  (link_w[k]),
      .dat_i   (dat_w[k]),
      .rank_i  (rank_w[k]),
      .link_o  (link_w[k+1]),
      .dat_o   (dat_w[k+1]),
      .rank_o  (rank_w[k+1])
    );
  end

  assign ex       = link_w[LIST_ENTRIES];
  assign ex_place = ex.active && ex.ins && ex.done;
  assign ex_read  = ex.active && !ex.ins && ex.done;

  // count, busy flag and the finished result
  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    fin_v   = 1'b0;
    fin     = '0;
    if (ex.active) begin
      busy_d = 1'b0;
      fin_v  = 1'b1;
      if (ex_place && (count_q < FullCnt)) begin
        count_d = count_q + CntW'(1);
      end
      fin.placed      = ex_place;
      fin.placed_rank = ex_place ? PrankW'(rank_w[LIST_ENTRIES]) : '0;
      fin.entry_valid = ex_read;
      if (ex_read) begin
        fin.entry_score = dat_w[LIST_ENTRIES].score;
        fin.entry_time  = dat_w[LIST_ENTRIES].time_ms;
        fin.entry_tag   = dat_w[LIST_ENTRIES].tag;
      end
    end else if (accept) begin
      if (walk_cmd) begin
        busy_d = 1'b1;
      end else begin
        fin_v = 1'b1;
        if (cmd == CMD_CLEAR) begin
          count_d = '0;
        end
      end
    end
    fin.entry_count = EcntW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      launch_q <= '0;
    end else begin
      count_q  <= count_d;
      busy_q   <= busy_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ldat_q <= ldat_d;
  end

  rtli_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fin_v),
    .push_data_i  (fin),
    .ready_i      (m_axis_tready_i),
    .valid_o      (m_axis_tvalid_o),
    .data_o       (out_data),
    .spare_full_o (spare_full)
  );

  assign m_axis_tdata_o = {4'd0, out_data};

`ifndef NO_ASSERTIONS
  logic [LIST_ENTRIES:0] act_vec;
  for (genvar j = 0; j <= LIST_ENTRIES; j++) begin : g_act
    assign act_vec[j] = link_w[j].active;
  end

  // only one token in the row at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one token in the cell row");

  // a token leaves the row only during a walk
  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex.active |-> busy_q)
    else $error("token left the row while idle");

  // the held count stays within the list size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("held count above list size");

  // no new beat is taken while a walk is under way
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && walk_cmd) |=> !s_axis_tready_o)
    else $error("input open during a walk");
`endif

endmodule

// File: test/ranked_top_list_insert_test.sv
module ranked_top_list_insert_test;
  import rtli_pkg::*;

  localparam int unsigned ListEntries = 32;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 40;
  // tuser value with no command behind it
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [30:0] ScoreMax = '1;
  localparam logic [31:0] TimeMax = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [87:0] s_data = '0;
  logic [1:0]  s_user = CMD_INSERT;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [95:0] m_axis_tdata_o;

  ranked_top_list_insert #(
    .LIST_ENTRIES(ListEntries)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // Predicted leaderboard contents and pending results
  entry_t      board[ListEntries];
  int unsigned board_cnt = 0;
  result_t     pending_results[$];

  int unsigned src_gap_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  int unsigned inserts_sent = 0;
  int unsigned entries_kept = 0;
  int unsigned entries_dropped = 0;
  int unsigned full_inserts = 0;
  int unsigned reads_sent = 0;
  int unsigned held_reads = 0;
  int unsigned clears_sent = 0;
  int unsigned unused_sent = 0;

  // Apply one command to the predicted board and return the result beat
  function automatic result_t rank_update(input logic [1:0] cmd, input entry_t e,
                                          input logic [4:0] rr);
    result_t     r;
    int unsigned pos;
    int unsigned last;
    bit          found;
    r = '0;
    found = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        pos = board_cnt;
        // first held entry that the new one outranks or ties
        for (int i = 0; i < board_cnt; i++) begin
          if (!found && (board[i].score < e.score ||
              (board[i].score == e.score && board[i].time_ms >= e.time_ms))) begin
            pos = i;
            found = 1'b1;
          end
        end
        if (pos < ListEntries) begin
          last = (board_cnt < ListEntries) ? board_cnt : ListEntries - 1;
          for (int i = last; i > pos; i--) board[i] = board[i-1];
          board[pos] = e;
          if (board_cnt < ListEntries) board_cnt++;
          r.placed = 1'b1;
          r.placed_rank = pos[PrankW-1:0];
        end
      end
      CMD_READ: begin
        if (rr < board_cnt) begin
          r.entry_valid = 1'b1;
          r.entry_score = board[rr].score;
          r.entry_time = board[rr].time_ms;
          r.entry_tag = board[rr].tag;
        end
      end
      CMD_CLEAR: begin
        board_cnt = 0;
      end
      default: ;
    endcase
    r.entry_count = board_cnt[EcntW-1:0];
    return r;
  endfunction

  // Send one beat, predict its result once it is taken
  task automatic send_beat(input logic [1:0] cmd, input logic [30:0] sc,
                           input logic [31:0] tm, input logic [15:0] tg,
                           input logic [4:0] rr);
    entry_t  e;
    result_t r;
    bit      was_full;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= {4'b0, rr, tg, tm, sc};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    e.score = sc;
    e.time_ms = tm;
    e.tag = tg;
    was_full = (board_cnt == ListEntries);
    r = rank_update(cmd, e, rr);
    pending_results.push_back(r);
    case (cmd)
      CMD_INSERT: begin
        inserts_sent++;
        if (was_full) full_inserts++;
        if (r.placed) entries_kept++;
        else entries_dropped++;
      end
      CMD_READ: begin
        reads_sent++;
        if (r.entry_valid) held_reads++;
      end
      CMD_CLEAR: clears_sent++;
      default: unused_sent++;
    endcase
  endtask

  // Hold the input off until every result is back
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // Result side: random stalls, compare each beat against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        check_field("placed", 32'(want.placed), 32'(got.placed));
        check_field("placed_rank", 32'(want.placed_rank), 32'(got.placed_rank));
        check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
        check_field("entry_score", 32'(want.entry_score), 32'(got.entry_score));
        check_field("entry_time", want.entry_time, got.entry_time);
        check_field("entry_tag", 32'(want.entry_tag), 32'(got.entry_tag));
        check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      end
      results_seen++;
    end
    m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Reads, a stray command and a clear on an empty list
  task automatic test_empty_list();
    send_beat(CMD_READ, '0, '0, '0, 5'd0);
    send_beat(CMD_READ, ScoreMax, TimeMax, 16'hffff, 5'd31);
    send_beat(CmdUnused, ScoreMax, TimeMax, 16'hffff, 5'd31);
    send_beat(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  // Extremes, score ties and time ties, read back, then a clear
  task automatic test_ordering();
    send_beat(CMD_INSERT, ScoreMax, TimeMax, 16'hffff, 5'd31);
    send_beat(CMD_INSERT, '0, '0, '0, '0);
    send_beat(CMD_INSERT, 31'd500, 32'd10, 16'h0a01, '0);
    send_beat(CMD_INSERT, 31'd500, 32'd15, 16'h0a02, '0);
    // ties a higher entry on score with a longer time: full ordered position
    send_beat(CMD_INSERT, 31'd500, 32'd20, 16'h0a03, '0);
    // equal score and time goes ahead of the held one
    send_beat(CMD_INSERT, 31'd500, 32'd10, 16'h0a04, '0);
    send_beat(CMD_INSERT, 31'd500, 32'd12, 16'h0a05, '0);
    send_beat(CMD_INSERT, '0, TimeMax, 16'h5a5a, '0);
    for (int r = 0; r < 9; r++) send_beat(CMD_READ, '0, '0, '0, 5'(r));
    send_beat(CMD_READ, '0, '0, '0, 5'd31);
    send_beat(CmdUnused, '0, '0, '0, '0);
    drain_results();
    send_beat(CMD_CLEAR, ScoreMax, TimeMax, 16'hffff, 5'd31);
    // stale storage behind an empty list must not show
    send_beat(CMD_READ, '0, '0, '0, 5'd0);
  endtask

  // Fill the list, then drop, push out and read the edges
  task automatic test_full_list();
    send_beat(CMD_CLEAR, '0, '0, '0, '0);
    for (int n = 0; n < ListEntries; n++)
      send_beat(CMD_INSERT, 31'($urandom_range(100, 150)), $urandom, 16'($urandom), '0);
    send_beat(CMD_INSERT, '0, TimeMax, 16'hdead, '0);
    send_beat(CMD_INSERT, ScoreMax, '0, 16'hbeef, '0);
    send_beat(CMD_INSERT, 31'd100, TimeMax, 16'h1234, '0);
    send_beat(CMD_READ, '0, '0, '0, 5'd31);
    send_beat(CMD_READ, '0, '0, '0, 5'd0);
    send_beat(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  // Mostly inserts and reads with tie-heavy content, rare clears and strays
  task automatic random_item();
    logic [1:0]  cmd;
    logic [30:0] sc;
    logic [31:0] tm;
    logic [4:0]  rr;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) cmd = CMD_INSERT;
    else if (pick < 97) cmd = CMD_READ;
    else if (pick < 98) cmd = CMD_CLEAR;
    else cmd = CmdUnused;
    case ($urandom_range(0, 3))
      0: sc = 31'($urandom);
      1: sc = $urandom_range(0, 1) ? ScoreMax : '0;
      default: sc = 31'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 3))
      0: tm = $urandom;
      1: tm = $urandom_range(0, 1) ? TimeMax : '0;
      default: tm = $urandom_range(0, 7);
    endcase
    if ($urandom_range(0, 3) != 0 && board_cnt != 0)
      rr = 5'($urandom_range(0, board_cnt - 1));
    else
      rr = 5'($urandom);
    send_beat(cmd, sc, tm, 16'($urandom), rr);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned src_pct,
                                     input int unsigned snk_pct);
    src_gap_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int k = 0; k < n; k++) begin
      random_item();
      if (k == n / 2) drain_results();
    end
  endtask

  initial begin
    src_gap_pct = 6;
    snk_stall_pct = 46;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_ordering();
    test_full_list();
    test_random_traffic(560, 6, 46);
    test_random_traffic(560, 46, 6);
    test_random_traffic(560, 0, 0);

    // let every result come back, then a short quiet tail
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    $display("inserts %0d (kept %0d, dropped %0d, into a full list %0d), reads %0d (%0d held)",
             inserts_sent, entries_kept, entries_dropped, full_inserts, reads_sent,
             held_reads);
    $display("clears %0d, stray commands %0d, %0d results checked, %0d mismatches",
             clears_sent, unused_sent, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
